// ----- hw/rtl/tqm_pkg.sv -----
package tqm_pkg;

    // Pool geometry and field widths
    localparam int TIMER_SLOTS = 16;
    localparam int TIME_BITS   = 48;
    localparam int PERIOD_BITS = 32;
    localparam int SLOT_W      = $clog2(TIMER_SLOTS);
    localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);
    localparam int SLOT_ID_W   = 4;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_TICK   = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_ADDED      = 3'd0,
        ST_FULL       = 3'd1,
        ST_CANCELLED  = 3'd2,
        ST_NOT_ACTIVE = 3'd3,
        ST_EXPIRED    = 3'd4,
        ST_TICK_DONE  = 3'd5
    } t_status;

    typedef enum logic {
        ALU_LT,
        ALU_ADD
    } t_alu_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_SCAN,
        S_ADD_FIN,
        S_CANCEL,
        S_MARK,
        S_PICK,
        S_REARM,
        S_MIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_cmd                   cmd;
        logic [SLOT_ID_W-1:0]   slot_id;
        logic [TIME_BITS-1:0]   deadline;
        logic [PERIOD_BITS-1:0] period;
        logic [TIME_BITS-1:0]   now;
    } t_in_beat;

    typedef struct packed {
        t_status              status;
        logic [SLOT_ID_W-1:0] slot_id_out;
        logic                 earliest_changed;
        logic [TIME_BITS-1:0] next_deadline;
        logic                 queue_nonempty;
        logic                 last;
    } t_out_beat;

    // Write side of the slot store
    typedef struct packed {
        logic                   dl_we;
        logic                   per_we;
        logic                   act_set;
        logic                   act_clr;
        logic [SLOT_W-1:0]      idx;
        logic [TIME_BITS-1:0]   dl;
        logic [PERIOD_BITS-1:0] per;
    } t_store_ctl;

endpackage

// ----- hw/rtl/tqm_alu.sv -----
module tqm_alu (
    input  tqm_pkg::t_alu_op                i_op,
    input  logic [tqm_pkg::TIME_BITS-1:0]   i_a,
    input  logic [tqm_pkg::TIME_BITS-1:0]   i_b,
    output logic                            o_lt,
    output logic [tqm_pkg::TIME_BITS-1:0]   o_sum_sat
);
    import tqm_pkg::*;

    logic [TIME_BITS:0]   w_full;
    logic [TIME_BITS-1:0] w_b;

    // One adder: a - b for the compare (carry out means a >= b), a + b for re-arm
    assign w_b    = (i_op == ALU_ADD) ? i_b : ~i_b;
    assign w_full = {1'b0, i_a} + {1'b0, w_b} + {{TIME_BITS{1'b0}}, (i_op == ALU_LT)};

    assign o_lt      = ~w_full[TIME_BITS];
    assign o_sum_sat = w_full[TIME_BITS] ? {TIME_BITS{1'b1}} : w_full[TIME_BITS-1:0];

endmodule

// ----- hw/rtl/tqm_slot_store.sv -----
module tqm_slot_store (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tqm_pkg::t_store_ctl               i_ctl,
    input  logic [tqm_pkg::SLOT_W-1:0]        i_rd_idx,
    output logic [tqm_pkg::TIME_BITS-1:0]     o_rd_dl,
    output logic [tqm_pkg::PERIOD_BITS-1:0]   o_rd_per,
    output logic [tqm_pkg::TIMER_SLOTS-1:0]   o_act
);
    import tqm_pkg::*;

    logic [TIMER_SLOTS-1:0] r_act;
    logic [TIME_BITS-1:0]   r_dl  [TIMER_SLOTS];
    logic [PERIOD_BITS-1:0] r_per [TIMER_SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= '0;
        end else if (i_ctl.act_set) begin
            r_act[i_ctl.idx] <= 1'b1;
        end else if (i_ctl.act_clr) begin
            r_act[i_ctl.idx] <= 1'b0;
        end
    end

    // Deadline and period are only read while the slot is active
    always_ff @(posedge i_clk) begin
        if (i_ctl.dl_we) begin
            r_dl[i_ctl.idx] <= i_ctl.dl;
        end
        if (i_ctl.per_we) begin
            r_per[i_ctl.idx] <= i_ctl.per;
        end
    end

    assign o_rd_dl  = r_dl[i_rd_idx];
    assign o_rd_per = r_per[i_rd_idx];
    assign o_act    = r_act;

endmodule

// ----- hw/rtl/timer_queue_manager_core.sv -----
// Timer queue manager over a pool of TIMER_SLOTS slots (deadline, period, active).
// Commands arrive one beat at a time on the input channel; the block stalls its
// input while a command is in work, and every command but the unused code gives
// one or more result beats, the final one marked last. All work runs through a
// single shared adder/comparator, one slot per cycle, so timing is set by slot
// scans: add finds the earliest deadline and a free slot, then writes it; cancel
// clears its slot and rescans; a tick that expires n timers marks them, picks
// them in deadline order in n + 1 passes, re-arms or frees each and rescans, then
// emits n + 1 beats at one per cycle when the output is not stalled. Every beat
// of a command reports the earliest deadline after the whole command. The
// result sits in an output register, so the next command is accepted while
// the last beat of the previous one still waits to be taken.
module timer_queue_manager_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tqm_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tqm_pkg::t_out_beat o_out_beat
);
    import tqm_pkg::*;

    // Sequencer state
    t_state               r_state, n_state;
    t_in_beat             r_in, n_in;
    logic [SLOT_W-1:0]    r_cnt, n_cnt;
    logic                 r_have, n_have;
    logic [TIME_BITS-1:0] r_best, n_best;
    logic [SLOT_W-1:0]    r_free, n_free;
    logic                 r_free_ok, n_free_ok;
    logic [SLOT_W-1:0]    r_pick, n_pick;
    logic [TIMER_SLOTS-1:0] r_pend, n_pend;
    logic [SLOT_W-1:0]    r_order [TIMER_SLOTS];
    logic [SLOT_W-1:0]    n_order [TIMER_SLOTS];
    logic [CNT_W-1:0]     r_n, n_n;
    logic [CNT_W-1:0]     r_k, n_k;
    t_status              r_fin_status, n_fin_status;
    logic [SLOT_ID_W-1:0] r_fin_slot, n_fin_slot;
    logic                 r_fin_chg, n_fin_chg;

    // Output register
    logic                 r_out_valid, n_out_valid;
    t_out_beat            r_out_beat, n_out_beat;

    // Shared unit and store
    t_alu_op              alu_op;
    logic [TIME_BITS-1:0] alu_a, alu_b, alu_sum;
    logic                 alu_lt;
    t_store_ctl           st_ctl;
    logic [SLOT_W-1:0]    rd_idx;
    logic [TIME_BITS-1:0] rd_dl;
    logic [PERIOD_BITS-1:0] rd_per;
    logic [TIMER_SLOTS-1:0] act;

    logic                 in_acc;
    logic                 out_load;
    logic                 cnt_last;
    logic                 cur_act;
    logic                 scan_take;
    logic                 pick_take;
    logic                 pick_have;
    logic [SLOT_W-1:0]    pick_idx;
    logic [SLOT_W-1:0]    k_idx;
    logic [SLOT_W-1:0]    sid_idx;
    logic                 sid_ok;
    logic                 rearm_last;

    tqm_alu u_alu (
        .i_op      (alu_op),
        .i_a       (alu_a),
        .i_b       (alu_b),
        .o_lt      (alu_lt),
        .o_sum_sat (alu_sum)
    );

    tqm_slot_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (st_ctl),
        .i_rd_idx (rd_idx),
        .o_rd_dl  (rd_dl),
        .o_rd_per (rd_per),
        .o_act    (act)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_load    = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    assign cnt_last   = (r_cnt == SLOT_W'(TIMER_SLOTS - 1));
    assign k_idx      = r_k[SLOT_W-1:0];
    assign sid_idx    = r_in.slot_id[SLOT_W-1:0];
    assign sid_ok     = (int'(r_in.slot_id) < TIMER_SLOTS);
    assign rearm_last = (r_k == CNT_W'(r_n - CNT_W'(1)));

    // Slot read address: re-arm walks the pick list, cancel looks at its slot,
    // everything else scans by counter.
    always_comb begin
        rd_idx = r_cnt;
        if (r_state == S_REARM) begin
            rd_idx = r_order[k_idx];
        end else if (r_state == S_CANCEL) begin
            rd_idx = sid_idx;
        end
    end

    assign cur_act   = act[rd_idx];
    assign scan_take = cur_act && (!r_have || alu_lt);
    assign pick_take = r_pend[r_cnt] && (!r_have || alu_lt);
    assign pick_have = r_have || pick_take;
    assign pick_idx  = pick_take ? r_cnt : r_pick;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_beat.cmd)
                        CMD_ADD:    n_state = S_ADD_SCAN;
                        CMD_CANCEL: n_state = S_CANCEL;
                        CMD_TICK:   n_state = S_MARK;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD_SCAN: if (cnt_last) n_state = S_ADD_FIN;
            S_ADD_FIN:  n_state = S_EMIT;
            S_CANCEL:   n_state = S_MIN;
            S_MARK:     if (cnt_last) n_state = S_PICK;
            S_PICK: begin
                if (cnt_last && !pick_have) begin
                    n_state = (r_n == '0) ? S_MIN : S_REARM;
                end
            end
            S_REARM:    if (rearm_last) n_state = S_MIN;
            S_MIN:      if (cnt_last) n_state = S_EMIT;
            S_EMIT:     if (out_load && (r_k == r_n)) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Datapath control and register updates
    always_comb begin
        n_in         = r_in;
        n_cnt        = r_cnt;
        n_have       = r_have;
        n_best       = r_best;
        n_free       = r_free;
        n_free_ok    = r_free_ok;
        n_pick       = r_pick;
        n_pend       = r_pend;
        n_order      = r_order;
        n_n          = r_n;
        n_k          = r_k;
        n_fin_status = r_fin_status;
        n_fin_slot   = r_fin_slot;
        n_fin_chg    = r_fin_chg;
        n_out_beat   = r_out_beat;
        n_out_valid  = i_out_stall ? r_out_valid : 1'b0;
        alu_op       = ALU_LT;
        alu_a        = rd_dl;
        alu_b        = r_best;
        st_ctl       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_in         = i_in_beat;
                    n_cnt        = '0;
                    n_have       = 1'b0;
                    n_free_ok    = 1'b0;
                    n_pend       = '0;
                    n_n          = '0;
                    n_k          = '0;
                    n_fin_status = ST_TICK_DONE;
                    n_fin_slot   = '0;
                    n_fin_chg    = 1'b0;
                end
            end
            S_ADD_SCAN: begin
                // earliest active deadline and lowest free slot in one pass
                if (scan_take) begin
                    n_best = rd_dl;
                    n_have = 1'b1;
                end
                if (!cur_act && !r_free_ok) begin
                    n_free    = r_cnt;
                    n_free_ok = 1'b1;
                end
                n_cnt = cnt_last ? '0 : r_cnt + SLOT_W'(1);
            end
            S_ADD_FIN: begin
                alu_a = r_in.deadline;
                if (r_free_ok) begin
                    st_ctl.dl_we   = 1'b1;
                    st_ctl.per_we  = 1'b1;
                    st_ctl.act_set = 1'b1;
                    st_ctl.idx     = r_free;
                    st_ctl.dl      = r_in.deadline;
                    st_ctl.per     = r_in.period;
                    n_fin_status   = ST_ADDED;
                    n_fin_slot     = SLOT_ID_W'(r_free);
                    n_fin_chg      = !r_have || alu_lt;
                    n_best         = (!r_have || alu_lt) ? r_in.deadline : r_best;
                    n_have         = 1'b1;
                end else begin
                    n_fin_status = ST_FULL;
                    n_fin_slot   = '0;
                    n_fin_chg    = 1'b0;
                end
            end
            S_CANCEL: begin
                if (sid_ok && cur_act) begin
                    st_ctl.act_clr = 1'b1;
                    st_ctl.idx     = sid_idx;
                    n_fin_status   = ST_CANCELLED;
                end else begin
                    n_fin_status = ST_NOT_ACTIVE;
                end
                n_fin_slot = r_in.slot_id;
                n_fin_chg  = 1'b0;
                n_cnt      = '0;
                n_have     = 1'b0;
            end
            S_MARK: begin
                // expired when !(now < deadline)
                alu_a         = r_in.now;
                alu_b         = rd_dl;
                n_pend[r_cnt] = cur_act && !alu_lt;
                n_cnt         = cnt_last ? '0 : r_cnt + SLOT_W'(1);
                n_have        = 1'b0;
            end
            S_PICK: begin
                // strict compare, ascending scan: ties go to the lowest slot
                if (pick_take) begin
                    n_best = rd_dl;
                    n_pick = r_cnt;
                    n_have = 1'b1;
                end
                n_cnt = cnt_last ? '0 : r_cnt + SLOT_W'(1);
                if (cnt_last) begin
                    n_have = 1'b0;
                    if (pick_have) begin
                        n_pend[pick_idx]            = 1'b0;
                        n_order[r_n[SLOT_W-1:0]]    = pick_idx;
                        n_n                         = r_n + CNT_W'(1);
                    end
                end
            end
            S_REARM: begin
                alu_op     = ALU_ADD;
                alu_a      = r_in.now;
                alu_b      = TIME_BITS'(rd_per);
                st_ctl.idx = rd_idx;
                if (rd_per != '0) begin
                    st_ctl.dl_we = 1'b1;
                    st_ctl.dl    = alu_sum;
                end else begin
                    st_ctl.act_clr = 1'b1;
                end
                n_k = r_k + CNT_W'(1);
            end
            S_MIN: begin
                if (scan_take) begin
                    n_best = rd_dl;
                    n_have = 1'b1;
                end
                n_cnt = cnt_last ? '0 : r_cnt + SLOT_W'(1);
                n_k   = '0;
            end
            S_EMIT: begin
                if (out_load) begin
                    n_out_valid                = 1'b1;
                    n_out_beat.next_deadline   = r_have ? r_best : '0;
                    n_out_beat.queue_nonempty  = r_have;
                    if (r_k == r_n) begin
                        n_out_beat.status           = r_fin_status;
                        n_out_beat.slot_id_out      = r_fin_slot;
                        n_out_beat.earliest_changed = r_fin_chg;
                        n_out_beat.last             = 1'b1;
                    end else begin
                        n_out_beat.status           = ST_EXPIRED;
                        n_out_beat.slot_id_out      = SLOT_ID_W'(r_order[k_idx]);
                        n_out_beat.earliest_changed = 1'b0;
                        n_out_beat.last             = 1'b0;
                        n_k                         = r_k + CNT_W'(1);
                    end
                end
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers and payload
    always_ff @(posedge i_clk) begin
        r_in         <= n_in;
        r_cnt        <= n_cnt;
        r_have       <= n_have;
        r_best       <= n_best;
        r_free       <= n_free;
        r_free_ok    <= n_free_ok;
        r_pick       <= n_pick;
        r_pend       <= n_pend;
        r_order      <= n_order;
        r_n          <= n_n;
        r_k          <= n_k;
        r_fin_status <= n_fin_status;
        r_fin_slot   <= n_fin_slot;
        r_fin_chg    <= n_fin_chg;
        r_out_beat   <= n_out_beat;
    end

    // An expiry beat never closes a tick
    a_expired_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_beat.status == ST_EXPIRED) |-> !o_out_beat.last)
        else $error("expiry beat marked last");

    // Empty queue reports a zero deadline
    a_empty_zero_dl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_beat.queue_nonempty |-> (o_out_beat.next_deadline == '0))
        else $error("empty queue with nonzero next deadline");

    // A real command always leaves idle
    a_cmd_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && ((i_in_beat.cmd == CMD_ADD) || (i_in_beat.cmd == CMD_CANCEL) ||
                   (i_in_beat.cmd == CMD_TICK)) |=> (r_state != S_IDLE))
        else $error("accepted command did not start");

    // Emit walk never runs past the pick list
    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_k <= r_n) && (r_n <= CNT_W'(TIMER_SLOTS)))
        else $error("emit index beyond pick list");

endmodule

// ----- tb/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tqm_pkg::*;

    // Unused command code; the block drops it without a beat.
    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         TAIL_CYCLES = 400;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         RANDOM_CMDS = 88;

    logic      i_clk     = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_beat  in_beat   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_beat out_beat;

    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        mismatches    = 0;
    int        cycle_count   = 0;

    // Timer pool as the block should hold it.
    logic                   slot_armed  [TIMER_SLOTS];
    logic [TIME_BITS-1:0]   slot_due    [TIMER_SLOTS];
    logic [PERIOD_BITS-1:0] slot_repeat [TIMER_SLOTS];
    // Beats owed by the block, oldest first.
    t_out_beat              timer_beats_q[$];
    // Running time base for well-formed random traffic.
    logic [TIME_BITS-1:0]   clock_now = 48'd1000;

    timer_queue_manager_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Pool model
    // ------------------------------------------------------------------

    // Earliest deadline among armed slots; any is low when the pool is empty.
    function automatic void earliest_armed(output logic any,
                                           output logic [TIME_BITS-1:0] best);
        any  = 1'b0;
        best = '0;
        for (int i = 0; i < TIMER_SLOTS; i++) begin
            if (slot_armed[i] && (!any || slot_due[i] < best)) begin
                best = slot_due[i];
                any  = 1'b1;
            end
        end
    endfunction

    // Applies one accepted command to the pool and queues the beats it owes.
    function automatic void apply_timer_cmd(input t_in_beat b);
        t_out_beat            beats[$];
        t_out_beat            r;
        logic                 any;
        logic [TIME_BITS-1:0] best;
        logic                 pend [TIMER_SLOTS];
        int                   order[$];
        int                   free_idx;
        int                   pick;
        int                   s;
        logic [TIME_BITS:0]   sum;

        r      = '0;
        r.last = 1'b1;
        case (b.cmd)
            CMD_ADD: begin
                free_idx = -1;
                for (int i = 0; i < TIMER_SLOTS; i++)
                    if (!slot_armed[i] && free_idx < 0) free_idx = i;
                if (free_idx < 0) begin
                    r.status = ST_FULL;     // pool full: slot 0, no change
                end else begin
                    earliest_armed(any, best);
                    r.status           = ST_ADDED;
                    r.slot_id_out      = free_idx[SLOT_ID_W-1:0];
                    r.earliest_changed = !any || (b.deadline < best);
                    slot_armed[free_idx]  = 1'b1;
                    slot_due[free_idx]    = b.deadline;
                    slot_repeat[free_idx] = b.period;
                end
                beats.push_back(r);
            end
            CMD_CANCEL: begin
                r.slot_id_out = b.slot_id;
                if (slot_armed[b.slot_id]) begin
                    r.status              = ST_CANCELLED;
                    slot_armed[b.slot_id] = 1'b0;
                end else begin
                    r.status = ST_NOT_ACTIVE;
                end
                beats.push_back(r);
            end
            CMD_TICK: begin
                for (int i = 0; i < TIMER_SLOTS; i++)
                    pend[i] = slot_armed[i] && (slot_due[i] <= b.now);
                // deadline order, ties to the lower slot
                do begin
                    pick = -1;
                    for (int i = 0; i < TIMER_SLOTS; i++)
                        if (pend[i] && (pick < 0 || slot_due[i] < slot_due[pick]))
                            pick = i;
                    if (pick >= 0) begin
                        pend[pick] = 1'b0;
                        order.push_back(pick);
                    end
                end while (pick >= 0);
                foreach (order[k]) begin
                    s = order[k];
                    if (slot_repeat[s] != '0) begin
                        sum         = {1'b0, b.now} + slot_repeat[s];
                        slot_due[s] = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
                    end else begin
                        slot_armed[s] = 1'b0;
                    end
                end
                r.status = ST_EXPIRED;
                r.last   = 1'b0;
                foreach (order[k]) begin
                    s             = order[k];
                    r.slot_id_out = s[SLOT_ID_W-1:0];
                    beats.push_back(r);
                end
                r.status      = ST_TICK_DONE;
                r.slot_id_out = '0;
                r.last        = 1'b1;
                beats.push_back(r);
            end
            default: ;  // dropped, no beat
        endcase

        // every beat of a command reports the pool after the whole command
        earliest_armed(any, best);
        foreach (beats[k]) begin
            beats[k].next_deadline  = any ? best : '0;
            beats[k].queue_nonempty = any;
            timer_beats_q.push_back(beats[k]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Output side: check each beat, then pick the next stall
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : beat_check
        t_out_beat want;
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            if (timer_beats_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: st=%0d slot=%0d chg=%b next=%h ne=%b last=%b",
                             out_beat.status, out_beat.slot_id_out,
                             out_beat.earliest_changed, out_beat.next_deadline,
                             out_beat.queue_nonempty, out_beat.last);
            end else begin
                want = timer_beats_q.pop_front();
                if (out_beat.status           !== want.status           ||
                    out_beat.slot_id_out      !== want.slot_id_out      ||
                    out_beat.earliest_changed !== want.earliest_changed ||
                    out_beat.next_deadline    !== want.next_deadline    ||
                    out_beat.queue_nonempty   !== want.queue_nonempty   ||
                    out_beat.last             !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"beat mismatch: exp st=%0d slot=%0d chg=%b next=%h ne=%b",
                                  " last=%b | got st=%0d slot=%0d chg=%b next=%h ne=%b",
                                  " last=%b"},
                                 want.status, want.slot_id_out, want.earliest_changed,
                                 want.next_deadline, want.queue_nonempty, want.last,
                                 out_beat.status, out_beat.slot_id_out,
                                 out_beat.earliest_changed, out_beat.next_deadline,
                                 out_beat.queue_nonempty, out_beat.last);
                end
            end
        end
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    function automatic logic [TIME_BITS-1:0] rand_time();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[TIME_BITS-1:0];
    endfunction

    // Fields a command ignores get random values.
    function automatic t_in_beat beat_of(input t_cmd c,
                                         input logic [SLOT_ID_W-1:0] slot,
                                         input logic [TIME_BITS-1:0] dl,
                                         input logic [PERIOD_BITS-1:0] per,
                                         input logic [TIME_BITS-1:0] now);
        t_in_beat b;
        b.cmd      = c;
        b.slot_id  = (c == CMD_CANCEL) ? slot : SLOT_ID_W'($urandom);
        b.deadline = (c == CMD_ADD)    ? dl   : rand_time();
        b.period   = (c == CMD_ADD)    ? per  : $urandom;
        b.now      = (c == CMD_TICK)   ? now  : rand_time();
        return b;
    endfunction

    // Sends one beat; valid stays high into the next beat when no gap follows.
    task automatic send_beat(input t_in_beat b);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge i_clk); while (in_stall !== 1'b0);
        apply_timer_cmd(b);
    endtask

    // Holds off input until every owed beat is back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (timer_beats_q.size() != 0) @(posedge i_clk);
    endtask

    // Mostly well-formed traffic around a moving time base.
    function automatic t_in_beat random_cmd();
        int                     roll;
        int                     armed[$];
        logic [TIME_BITS-1:0]   dl;
        logic [PERIOD_BITS-1:0] per;
        logic [SLOT_ID_W-1:0]   slot;
        t_in_beat               b;

        roll = $urandom_range(0, 99);
        if (roll < 42) begin
            dl = ($urandom_range(0, 9) == 0) ? rand_time()
                                             : clock_now + $urandom_range(0, 300);
            case ($urandom_range(0, 19))
                0, 1:    per = $urandom;
                2:       per = '1;
                3, 4, 5, 6, 7, 8, 9:
                         per = $urandom_range(1, 200);
                default: per = '0;
            endcase
            b = beat_of(CMD_ADD, '0, dl, per, '0);
        end else if (roll < 57) begin
            for (int i = 0; i < TIMER_SLOTS; i++)
                if (slot_armed[i]) armed.push_back(i);
            if (armed.size() != 0 && $urandom_range(0, 99) < 75)
                slot = SLOT_ID_W'(armed[$urandom_range(0, armed.size() - 1)]);
            else
                slot = SLOT_ID_W'($urandom);
            b = beat_of(CMD_CANCEL, slot, '0, '0, '0);
        end else if (roll < 95) begin
            if ($urandom_range(0, 19) == 0) begin
                // off-base time, far ahead or behind
                b = beat_of(CMD_TICK, '0, '0, '0,
                            $urandom_range(0, 1) ? rand_time() : '1);
            end else begin
                clock_now = clock_now + $urandom_range(0, 150);
                b = beat_of(CMD_TICK, '0, '0, '0, clock_now);
            end
        end else begin
            b     = beat_of(CMD_TICK, '0, '0, '0, '0);
            b.cmd = t_cmd'(CMD_UNUSED);
        end
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Fill all slots (empty pool, tie, new minimum, extremes), then one more.
    task automatic test_fill_pool();
        send_beat(beat_of(CMD_ADD, '0, 48'd100, 32'd0, '0));
        send_beat(beat_of(CMD_ADD, '0, 48'd100, 32'd7, '0));
        send_beat(beat_of(CMD_ADD, '0, 48'd50,  32'd0, '0));
        send_beat(beat_of(CMD_ADD, '0, '1,      '1,    '0));
        send_beat(beat_of(CMD_ADD, '0, 48'd0,   32'd1, '0));
        for (int i = 5; i < TIMER_SLOTS; i++)
            send_beat(beat_of(CMD_ADD, '0, 48'd200 + 48'(i * 10),
                              (i % 2) ? 32'd0 : 32'd3, '0));
        send_beat(beat_of(CMD_ADD, '0, 48'd1, 32'd0, '0));
    endtask

    // Cancel of a live slot, then of the same slot once it is free.
    task automatic test_cancel();
        send_beat(beat_of(CMD_CANCEL, 4'd15, '0, '0, '0));
        send_beat(beat_of(CMD_CANCEL, 4'd15, '0, '0, '0));
    endtask

    // Expiry order by deadline with a tie; periodic re-arm and one-shot free.
    task automatic test_tick_order();
        send_beat(beat_of(CMD_TICK, '0, '0, '0, 48'd100));
    endtask

    // Tick at the top of time: everything expires, re-arms saturate.
    task automatic test_rearm_saturation();
        send_beat(beat_of(CMD_TICK, '0, '0, '0, '1));
    endtask

    task automatic test_unused_cmd();
        t_in_beat b;
        b     = beat_of(CMD_TICK, '0, '0, '0, '0);
        b.cmd = t_cmd'(CMD_UNUSED);
        send_beat(b);
    endtask

    task automatic test_random_traffic(input int count, input int s_pct, input int r_pct);
        t_in_beat b;
        int       sent;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        sent          = 0;
        while (sent < count) begin
            b = random_cmd();
            send_beat(b);
            if (b.cmd != t_cmd'(CMD_UNUSED)) sent++;
        end
    endtask

    initial begin
        foreach (slot_armed[i]) begin
            slot_armed[i]  = 1'b0;
            slot_due[i]    = '0;
            slot_repeat[i] = '0;
        end
        send_idle_pct = 11;
        recv_idle_pct = 79;
        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;

        test_fill_pool();
        test_cancel();
        test_tick_order();
        drain_results();
        test_rearm_saturation();
        test_unused_cmd();

        test_random_traffic(RANDOM_CMDS / 3, 11, 79);
        drain_results();
        test_random_traffic(RANDOM_CMDS / 3, 79, 11);
        drain_results();
        test_random_traffic(RANDOM_CMDS - 2 * (RANDOM_CMDS / 3), 0, 0);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
